// ===== rtl/core/bsg_pkg.sv =====
// ----------------------------------------------------------------------------
// bsg_pkg
// Shared types and constants of the grid box splitter: widths, rank limit,
// shared unit operation codes and the state encodings of both sequencers.
// ----------------------------------------------------------------------------
package bsg_pkg;

	// box rank limit and derived widths
	localparam int MAX_RANK = 32;
	localparam int DIM_W    = $clog2(MAX_RANK + 1);
	localparam int AXIS_W   = 5;

	// field widths
	localparam int COORD_W = 63;
	localparam int STEP_W  = 62;
	localparam int WORD_W  = 64;
	localparam int SPAN_W  = 65;

	// iteration counts of the shared unit
	localparam int DIV_STEPS = 64;
	localparam int MUL_STEPS = 62;
	localparam int CNT_W     = 6;

	// shared unit operations
	typedef enum logic {
		OP_DIV,
		OP_MUL
	} bsg_op_t;

	// shared unit sequencer states
	typedef enum logic [2:0] {
		U_IDLE,
		U_NEG,
		U_DIV,
		U_FIX,
		U_MUL
	} bsg_ustate_t;

	// top level sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_DIV_LO,
		S_DIV_HI,
		S_PICK,
		S_MID_SUM,
		S_MID_HALF,
		S_MUL,
		S_EMIT
	} bsg_state_t;

	// request to the shared unit
	typedef struct packed {
		logic                start;
		bsg_op_t             op;
		logic [WORD_W-1:0]   opa;
		logic [STEP_W-1:0]   opb;
		logic [COORD_W-1:0]  opc;
	} bsg_req_t;

	// response from the shared unit
	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] result;
	} bsg_rsp_t;

endpackage

// ===== rtl/core/bsg_item_if.sv =====
// ----------------------------------------------------------------------------
// bsg_item_if
// Input channel of the splitter: one beat per box dimension.
// ----------------------------------------------------------------------------
interface bsg_item_if;

	logic                                  valid;
	logic                                  ready;
	logic signed [bsg_pkg::COORD_W-1:0]    box_low;
	logic signed [bsg_pkg::COORD_W-1:0]    box_high;
	logic signed [bsg_pkg::COORD_W-1:0]    grid_origin;
	logic        [bsg_pkg::STEP_W-1:0]     grid_step;
	logic                                  final_dim;

	modport source (
		output valid, box_low, box_high, grid_origin, grid_step, final_dim,
		input  ready
	);

	modport sink (
		input  valid, box_low, box_high, grid_origin, grid_step, final_dim,
		output ready
	);

endinterface

// ===== rtl/core/bsg_result_if.sv =====
// ----------------------------------------------------------------------------
// bsg_result_if
// Output channel of the splitter: one beat per box.
// ----------------------------------------------------------------------------
interface bsg_result_if;

	logic                                  valid;
	logic                                  ready;
	logic                                  split_found;
	logic        [bsg_pkg::AXIS_W-1:0]     split_axis;
	logic signed [bsg_pkg::COORD_W-1:0]    split_point;
	logic signed [bsg_pkg::COORD_W-1:0]    lower_start;
	logic signed [bsg_pkg::WORD_W-1:0]     upper_end;

	modport source (
		output valid, split_found, split_axis, split_point, lower_start, upper_end,
		input  ready
	);

	modport sink (
		input  valid, split_found, split_axis, split_point, lower_start, upper_end,
		output ready
	);

endinterface

// ===== rtl/core/bsg_iter_unit.sv =====
// ----------------------------------------------------------------------------
// bsg_iter_unit
// Shared iterative arithmetic unit around one 64-bit adder: signed floor
// division by a positive step (radix 2, one quotient bit per cycle) and
// shift-add multiply-accumulate modulo 2^63 (one multiplier bit per cycle).
// ----------------------------------------------------------------------------
module bsg_iter_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  bsg_pkg::bsg_req_t req,
	output bsg_pkg::bsg_rsp_t rsp
);

	bsg_pkg::bsg_ustate_t state_q, state_d;
	bsg_pkg::bsg_op_t     op_q;

	logic [bsg_pkg::WORD_W-1:0]  acc_q;
	logic [bsg_pkg::WORD_W-1:0]  dq_q;
	logic [bsg_pkg::STEP_W-1:0]  dvs_q;
	logic [bsg_pkg::CNT_W-1:0]   cnt_q;
	logic                        neg_q;
	logic                        done_q;

	// the one shared adder
	logic [bsg_pkg::WORD_W-1:0] add_x;
	logic [bsg_pkg::WORD_W-1:0] add_y;
	logic                       add_inv;
	logic                       add_cin;
	logic [bsg_pkg::WORD_W-1:0] add_sum;

	// partial remainder shifted by one dividend bit
	logic [bsg_pkg::COORD_W-1:0] shift_rem;
	logic                        last_step;

	assign add_sum   = add_x + (add_inv ? ~add_y : add_y)
		+ {{(bsg_pkg::WORD_W-1){1'b0}}, add_cin};
	assign shift_rem = {acc_q[bsg_pkg::STEP_W-1:0], dq_q[bsg_pkg::WORD_W-1]};

	// next state and adder operand selection
	always_comb begin
		state_d   = state_q;
		add_x     = '0;
		add_y     = dq_q;
		add_inv   = 1'b0;
		add_cin   = 1'b0;
		last_step = 1'b0;
		case (state_q)
			bsg_pkg::U_IDLE: begin
				if (req.start) begin
					state_d = (req.op == bsg_pkg::OP_DIV) ? bsg_pkg::U_NEG : bsg_pkg::U_MUL;
				end
			end
			bsg_pkg::U_NEG: begin
				// magnitude of the dividend
				add_inv = 1'b1;
				add_cin = 1'b1;
				state_d = bsg_pkg::U_DIV;
			end
			bsg_pkg::U_DIV: begin
				// trial subtract of the step
				add_x     = {1'b0, shift_rem};
				add_y     = {2'b00, dvs_q};
				add_inv   = 1'b1;
				add_cin   = 1'b1;
				last_step = (cnt_q == bsg_pkg::CNT_W'(bsg_pkg::DIV_STEPS - 1));
				if (last_step) begin
					state_d = bsg_pkg::U_FIX;
				end
			end
			bsg_pkg::U_FIX: begin
				// negative dividend: floor quotient is ~q plus one on exact division
				add_inv = 1'b1;
				add_cin = (acc_q == '0);
				state_d = bsg_pkg::U_IDLE;
			end
			bsg_pkg::U_MUL: begin
				add_x     = acc_q;
				add_y     = dq_q;
				last_step = (cnt_q == bsg_pkg::CNT_W'(bsg_pkg::MUL_STEPS - 1));
				if (last_step) begin
					state_d = bsg_pkg::U_IDLE;
				end
			end
			default: begin
				state_d = bsg_pkg::U_IDLE;
			end
		endcase
	end

	// sequencer state and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsg_pkg::U_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == bsg_pkg::U_FIX)
				|| (state_q == bsg_pkg::U_MUL && last_step);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			bsg_pkg::U_IDLE: begin
				if (req.start) begin
					op_q  <= req.op;
					dq_q  <= req.opa;
					dvs_q <= req.opb;
					neg_q <= req.opa[bsg_pkg::WORD_W-1];
					cnt_q <= '0;
					acc_q <= (req.op == bsg_pkg::OP_DIV) ? '0 : {1'b0, req.opc};
				end
			end
			bsg_pkg::U_NEG: begin
				if (neg_q) begin
					dq_q <= add_sum;
				end
			end
			bsg_pkg::U_DIV: begin
				cnt_q <= cnt_q + 1'b1;
				if (!add_sum[bsg_pkg::WORD_W-1]) begin
					acc_q <= {2'b00, add_sum[bsg_pkg::STEP_W-1:0]};
					dq_q  <= {dq_q[bsg_pkg::WORD_W-2:0], 1'b1};
				end else begin
					acc_q <= {2'b00, shift_rem[bsg_pkg::STEP_W-1:0]};
					dq_q  <= {dq_q[bsg_pkg::WORD_W-2:0], 1'b0};
				end
			end
			bsg_pkg::U_FIX: begin
				if (neg_q) begin
					dq_q <= add_sum;
				end
			end
			bsg_pkg::U_MUL: begin
				cnt_q <= cnt_q + 1'b1;
				if (dvs_q[0]) begin
					acc_q <= {1'b0, add_sum[bsg_pkg::COORD_W-1:0]};
				end
				dq_q  <= {dq_q[bsg_pkg::WORD_W-2:0], 1'b0};
				dvs_q <= {1'b0, dvs_q[bsg_pkg::STEP_W-1:1]};
			end
			default: begin
			end
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.result = (op_q == bsg_pkg::OP_MUL) ? acc_q : dq_q;

endmodule

// ===== rtl/core/box_split_by_grid_unit.sv =====
// ----------------------------------------------------------------------------
// box_split_by_grid_unit
// Grid-aligned box splitter: picks the dimension spanning the most grid
// cells and reports the split coordinate at the middle cell boundary.
// ----------------------------------------------------------------------------
// Usage: send one beat per box dimension on item (bounds, grid origin and
// step); the beat with final_dim set closes the box. One result beat per box
// leaves on result. Only the first 32 dimensions of a box take part.
// Each dimension runs two floor divisions on the shared radix-2 unit, one
// quotient bit per cycle; item is not ready again until both are done. A
// closing beat with a split adds the middle coordinate multiply on the same
// unit; the result beat is loaded into the output register once it is free.
// Dimensions past the rank limit skip the divisions.
// item.ready is low while a dimension is being worked on; the shared unit
// sets the rate. The result sits in an output register, so a stalled
// receiver does not block the next dimensions; only a second closing beat
// waits until the previous result is taken.
// Reset (arst_n low) clears the box state and drops result.valid.
// ----------------------------------------------------------------------------
module box_split_by_grid_unit (
	input  logic                clk,
	input  logic                arst_n,
	bsg_item_if.sink            item,
	bsg_result_if.source        result
);

	bsg_pkg::bsg_state_t state_q, state_d;
	bsg_pkg::bsg_req_t   req;
	bsg_pkg::bsg_rsp_t   rsp;

	// current dimension
	logic signed [bsg_pkg::COORD_W-1:0] low_q, high_q, org_q;
	logic        [bsg_pkg::STEP_W-1:0]  step_q;
	logic                               last_q;
	logic        [bsg_pkg::WORD_W-1:0]  dhi_q;
	logic        [bsg_pkg::WORD_W-1:0]  first_q;
	logic        [bsg_pkg::WORD_W-1:0]  qhi_q;

	// best dimension of the box so far
	logic [bsg_pkg::DIM_W-1:0]          dim_cnt_q;
	logic                               found_q;
	logic signed [bsg_pkg::SPAN_W-1:0]  best_span_q;
	logic [bsg_pkg::AXIS_W-1:0]         best_axis_q;
	logic [bsg_pkg::WORD_W-1:0]         best_first_q;
	logic [bsg_pkg::WORD_W-1:0]         best_qhi_q;
	logic [bsg_pkg::COORD_W-1:0]        best_org_q;
	logic [bsg_pkg::STEP_W-1:0]         best_step_q;
	logic [bsg_pkg::COORD_W-1:0]        best_low_q;
	logic [bsg_pkg::COORD_W-1:0]        best_high_q;

	// middle cell and split point
	logic signed [bsg_pkg::SPAN_W-1:0]  mid_sum_q;
	logic [bsg_pkg::COORD_W-1:0]        point_q;

	// output register
	logic                               out_valid_q;
	logic                               out_found_q;
	logic [bsg_pkg::AXIS_W-1:0]         out_axis_q;
	logic [bsg_pkg::COORD_W-1:0]        out_point_q;
	logic [bsg_pkg::COORD_W-1:0]        out_low_q;
	logic [bsg_pkg::WORD_W-1:0]         out_end_q;

	logic                               in_fire;
	logic                               in_rank;
	logic                               out_free;
	logic signed [bsg_pkg::SPAN_W-1:0]  span_raw;
	logic                               take_dim;
	logic [bsg_pkg::WORD_W-1:0]         dlo;
	logic [bsg_pkg::COORD_W-1:0]        half_lo;

	assign in_fire  = item.valid && item.ready;
	assign in_rank  = (dim_cnt_q < bsg_pkg::DIM_W'(bsg_pkg::MAX_RANK));
	assign out_free = !out_valid_q || result.ready;

	// offset of the lower bound from the grid origin
	assign dlo = {low_q[bsg_pkg::COORD_W-1], low_q} - {org_q[bsg_pkg::COORD_W-1], org_q};

	// cell span less one; beats the best span only when strictly larger
	assign span_raw = $signed({qhi_q[bsg_pkg::WORD_W-1], qhi_q})
		- $signed({first_q[bsg_pkg::WORD_W-1], first_q});
	assign take_dim = (span_raw > best_span_q);

	// middle cell index halved toward zero, low bits only
	assign half_lo = mid_sum_q[bsg_pkg::WORD_W-1:1]
		+ {{(bsg_pkg::COORD_W-1){1'b0}}, mid_sum_q[bsg_pkg::SPAN_W-1] & mid_sum_q[0]};

	bsg_iter_unit u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// next state, handshake and unit requests
	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		req.start  = 1'b0;
		req.op     = bsg_pkg::OP_DIV;
		req.opa    = dlo;
		req.opb    = step_q;
		req.opc    = best_org_q;
		case (state_q)
			bsg_pkg::S_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					state_d = bsg_pkg::S_PREP;
				end
			end
			bsg_pkg::S_PREP: begin
				if (in_rank) begin
					req.start = 1'b1;
					state_d   = bsg_pkg::S_DIV_LO;
				end else if (!last_q) begin
					state_d = bsg_pkg::S_IDLE;
				end else if (found_q) begin
					state_d = bsg_pkg::S_MID_SUM;
				end else begin
					state_d = bsg_pkg::S_EMIT;
				end
			end
			bsg_pkg::S_DIV_LO: begin
				if (rsp.done) begin
					req.start = 1'b1;
					req.opa   = dhi_q;
					state_d   = bsg_pkg::S_DIV_HI;
				end
			end
			bsg_pkg::S_DIV_HI: begin
				if (rsp.done) begin
					state_d = bsg_pkg::S_PICK;
				end
			end
			bsg_pkg::S_PICK: begin
				if (!last_q) begin
					state_d = bsg_pkg::S_IDLE;
				end else if (found_q || take_dim) begin
					state_d = bsg_pkg::S_MID_SUM;
				end else begin
					state_d = bsg_pkg::S_EMIT;
				end
			end
			bsg_pkg::S_MID_SUM: begin
				state_d = bsg_pkg::S_MID_HALF;
			end
			bsg_pkg::S_MID_HALF: begin
				req.start = 1'b1;
				req.op    = bsg_pkg::OP_MUL;
				req.opa   = {1'b0, half_lo};
				req.opb   = best_step_q;
				state_d   = bsg_pkg::S_MUL;
			end
			bsg_pkg::S_MUL: begin
				if (rsp.done) begin
					state_d = bsg_pkg::S_EMIT;
				end
			end
			bsg_pkg::S_EMIT: begin
				if (out_free) begin
					state_d = bsg_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bsg_pkg::S_IDLE;
			end
		endcase
	end

	// control state: sequencer, box bookkeeping, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bsg_pkg::S_IDLE;
			dim_cnt_q   <= '0;
			found_q     <= 1'b0;
			best_span_q <= '0;
			best_axis_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bsg_pkg::S_PICK) begin
				dim_cnt_q <= dim_cnt_q + 1'b1;
				if (take_dim) begin
					found_q     <= 1'b1;
					best_span_q <= span_raw;
					best_axis_q <= dim_cnt_q[bsg_pkg::AXIS_W-1:0];
				end
			end
			// load a new result beat, or drop valid once the beat is taken
			if (state_q == bsg_pkg::S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
				dim_cnt_q   <= '0;
				found_q     <= 1'b0;
				best_span_q <= '0;
				best_axis_q <= '0;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			low_q  <= item.box_low;
			high_q <= item.box_high;
			org_q  <= item.grid_origin;
			step_q <= (item.grid_step == '0) ? bsg_pkg::STEP_W'(1) : item.grid_step;
			last_q <= item.final_dim;
		end
		if (state_q == bsg_pkg::S_PREP) begin
			dhi_q <= {high_q[bsg_pkg::COORD_W-1], high_q} - {org_q[bsg_pkg::COORD_W-1], org_q};
		end
		if (state_q == bsg_pkg::S_DIV_LO && rsp.done) begin
			first_q <= rsp.result;
		end
		if (state_q == bsg_pkg::S_DIV_HI && rsp.done) begin
			qhi_q <= rsp.result;
		end
		if (state_q == bsg_pkg::S_PICK && take_dim) begin
			best_first_q <= first_q;
			best_qhi_q   <= qhi_q;
			best_org_q   <= org_q;
			best_step_q  <= step_q;
			best_low_q   <= low_q;
			best_high_q  <= high_q;
		end
		// first cell plus end cell, end being the upper floor quotient plus one
		if (state_q == bsg_pkg::S_MID_SUM) begin
			mid_sum_q <= $signed({best_first_q[bsg_pkg::WORD_W-1], best_first_q})
				+ $signed({best_qhi_q[bsg_pkg::WORD_W-1], best_qhi_q})
				+ $signed(bsg_pkg::SPAN_W'(1));
		end
		if (state_q == bsg_pkg::S_MUL && rsp.done) begin
			point_q <= rsp.result[bsg_pkg::COORD_W-1:0];
		end
		// load the result beat
		if (state_q == bsg_pkg::S_EMIT && out_free) begin
			out_found_q <= found_q;
			if (found_q) begin
				out_axis_q  <= best_axis_q;
				out_point_q <= point_q;
				out_low_q   <= best_low_q;
				out_end_q   <= {best_high_q[bsg_pkg::COORD_W-1], best_high_q}
					+ bsg_pkg::WORD_W'(1);
			end else begin
				out_axis_q  <= '0;
				out_point_q <= '0;
				out_low_q   <= '0;
				out_end_q   <= '0;
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.split_found = out_found_q;
	assign result.split_axis  = out_axis_q;
	assign result.split_point = out_point_q;
	assign result.lower_start = out_low_q;
	assign result.upper_end   = out_end_q;

endmodule
